// ===== rtl/uvsmg_pkg.sv =====
// Shared types and constants for the UV sphere mesh generator.
package uvsmg_pkg;

    localparam logic [2:0] KIND_POS = 3'd0;
    localparam logic [2:0] KIND_TEX = 3'd1;
    localparam logic [2:0] KIND_NRM = 3'd2;
    localparam logic [2:0] KIND_TAN = 3'd3;
    localparam logic [2:0] KIND_BIT = 3'd4;
    localparam logic [2:0] KIND_TRI = 3'd5;
    localparam logic [2:0] KIND_ERR = 3'd6;

    localparam logic [2:0] ADDR_U_SEG  = 3'd0;
    localparam logic [2:0] ADDR_V_RING = 3'd1;
    localparam logic [2:0] ADDR_RADIUS = 3'd2;
    localparam logic [2:0] ADDR_CX     = 3'd3;
    localparam logic [2:0] ADDR_CY     = 3'd4;
    localparam logic [2:0] ADDR_CZ     = 3'd5;
    localparam logic [2:0] ADDR_ATTR   = 3'd6;

    localparam int CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] UNIT_ONE = 34'sd16384;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } sc_t;

    function automatic logic [31:0] atan_q(input logic [3:0] k);
        logic [31:0] r;
        unique case (k)
            4'd0:    r = 32'd536870912;
            4'd1:    r = 32'd316933406;
            4'd2:    r = 32'd167458907;
            4'd3:    r = 32'd85004756;
            4'd4:    r = 32'd42667331;
            4'd5:    r = 32'd21354465;
            4'd6:    r = 32'd10679838;
            4'd7:    r = 32'd5340245;
            4'd8:    r = 32'd2670163;
            4'd9:    r = 32'd1335087;
            4'd10:   r = 32'd667544;
            4'd11:   r = 32'd333772;
            4'd12:   r = 32'd166886;
            4'd13:   r = 32'd83443;
            4'd14:   r = 32'd41722;
            default: r = 32'd20861;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/uvsmg_if.sv =====
// Request and result channel interfaces.
interface uvsmg_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [10:0] ring;
    logic [10:0] segment;

    modport source (output valid, op, ring, segment, input ready);
    modport sink   (input valid, op, ring, segment, output ready);
endinterface

interface uvsmg_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic        last;

    modport source (output valid, kind, value_a, value_b, value_c, last, input ready);
    modport sink   (input valid, kind, value_a, value_b, value_c, last, output ready);
endinterface

// ===== rtl/uvsmg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module uvsmg_div #(
    parameter int QW = 17
) (
    input  logic              clk,
    input  logic              en,
    input  logic [QW+10:0]    dividend,
    input  logic [10:0]       divisor,
    output logic [QW-1:0]     quotient
);
    logic [10:0]   rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [10:0]   dsr_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [10:0]   rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [10:0]   dsr_in;
        logic [11:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = dividend[QW+10:QW];
            assign low_in = dividend[QW-1:0];
            assign quo_in = '0;
            assign dsr_in = divisor;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dsr_in = dsr_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = trial >= {1'b0, dsr_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? 11'(trial - {1'b0, dsr_in}) : trial[10:0];
                low_reg[k] <= low_in << 1;
                quo_reg[k] <= {quo_in[QW-2:0], ge};
                dsr_reg[k] <= dsr_in;
            end
        end
    end

    assign quotient = quo_reg[QW-1];
endmodule

// ===== rtl/uvsmg_cordic.sv =====
// Pipelined rotation CORDIC: phase to Q2.14 cosine and sine.
module uvsmg_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] phase,
    output uvsmg_pkg::sc_t        sc
);
    import uvsmg_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STEPS+1];
    logic signed [33:0] y_reg [CORDIC_STEPS+1];
    logic signed [33:0] z_reg [CORDIC_STEPS+1];
    logic               neg_reg [CORDIC_STEPS+1];
    sc_t                sc_reg;

    logic [31:0] p_full;
    logic [31:0] p_turn;
    logic [31:0] p_fold;

    assign p_full = {phase, {(32-ANGLE_BITS){1'b0}}};
    assign p_turn = p_full + 32'h4000_0000;
    assign p_fold = p_turn[31] ? (p_full ^ 32'h8000_0000) : p_full;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= 34'(signed'(p_fold));
            neg_reg[0] <= p_turn[31];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        assign at = signed'({2'b00, atan_q(4'(k))});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[k][33])
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - at;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + at;
                end
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    function automatic logic signed [15:0] fin(input logic signed [33:0] v, input logic neg);
        logic signed [33:0] r;
        logic signed [15:0] c;
        r = (v + 34'sd32768) >>> 16;
        if (r > UNIT_ONE)
            c = 16'sd16384;
        else if (r < -UNIT_ONE)
            c = -16'sd16384;
        else
            c = r[15:0];
        return neg ? -c : c;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg.c <= fin(x_reg[CORDIC_STEPS], neg_reg[CORDIC_STEPS]);
            sc_reg.s <= fin(y_reg[CORDIC_STEPS], neg_reg[CORDIC_STEPS]);
        end
    end

    assign sc = sc_reg;
endmodule

// ===== rtl/uv_sphere_mesh_generator_top.sv =====
// UV sphere tessellator top level: config port, pipeline and beat sequencer.
//
//  channel | dir | protocol        | payload
//  --------+-----+-----------------+-------------------------------------------
//  req     | in  | valid/ready     | op, ring, segment
//  rsp     | out | valid/ready     | kind, value_a, value_b, value_c, last
//  apb     | in  | APB, pready = 1 | paddr[4:2] selects register, pwdata
//
//  A request passes stage A, the bit-per-stage dividers, the 16-step CORDIC and stages M,
//  P1 and P2 to the beat sequencer; QW = max(ANGLE_BITS+1, 16) is the quotient width.
//  A request enters every cycle while the pipeline advances; the result channel moves one
//  beat per cycle while ready is high; a vertex sends up to five beats, a cell up to two.
//  While the last stage holds a valid request, a stalled result freezes every stage;
//  nothing is dropped or repeated. Reset clears valid bits and loads the register defaults.
module uv_sphere_mesh_generator_top #(
    parameter int MAX_RESOLUTION = 1024,
    parameter int ANGLE_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    uvsmg_req_if.sink   req,
    uvsmg_rsp_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uvsmg_pkg::*;

    localparam int QW = (ANGLE_BITS + 1 > 16) ? ANGLE_BITS + 1 : 16;
    localparam int DW = QW + 11;
    localparam int NM = QW + 22;
    localparam int NT = 21;
    localparam logic [12:0] MAX_RES = 13'(MAX_RESOLUTION);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    typedef struct packed {
        logic        op;
        logic        ok;
        logic        tri_a;
        logic        tri_b;
        logic [21:0] k1;
        logic [21:0] k2;
        logic [10:0] ring;
        logic [10:0] segment;
    } meta_t;

    typedef struct packed {
        logic [15:0] tu;
        logic [15:0] tv;
    } tex_t;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic signed [15:0] cu;
        logic signed [15:0] su;
        logic signed [15:0] cv;
        logic signed [16:0] bx;
        logic signed [16:0] bz;
    } vtx_t;

    // configuration
    logic [10:0] u_seg_reg;
    logic [10:0] v_ring_reg;
    logic [30:0] radius_reg;
    logic [31:0] cx_reg;
    logic [31:0] cy_reg;
    logic [31:0] cz_reg;
    logic [2:0]  attr_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_seg_reg  <= 11'd32;
            v_ring_reg <= 11'd16;
            radius_reg <= 31'd65536;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            attr_reg   <= 3'd3;
        end
        else if (wr)
        begin
            unique case (paddr[4:2])
                ADDR_U_SEG:  u_seg_reg  <= pwdata[10:0];
                ADDR_V_RING: v_ring_reg <= pwdata[10:0];
                ADDR_RADIUS: radius_reg <= pwdata[30:0];
                ADDR_CX:     cx_reg     <= pwdata;
                ADDR_CY:     cy_reg     <= pwdata;
                ADDR_CZ:     cz_reg     <= pwdata;
                ADDR_ATTR:   attr_reg   <= pwdata[2:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            ADDR_U_SEG:  prdata = {21'd0, u_seg_reg};
            ADDR_V_RING: prdata = {21'd0, v_ring_reg};
            ADDR_RADIUS: prdata = {1'b0, radius_reg};
            ADDR_CX:     prdata = cx_reg;
            ADDR_CY:     prdata = cy_reg;
            ADDR_CZ:     prdata = cz_reg;
            ADDR_ATTR:   prdata = {29'd0, attr_reg};
            default:     prdata = '0;
        endcase
    end

    // pipeline control
    logic       adv;
    logic       emit_free;
    logic [4:0] pend_reg;
    logic       beat_last;

    logic  vld_reg  [NM];
    meta_t meta_reg [NM];

    assign req.ready = adv;

    // stage A: range check and cell indices
    meta_t       a_next;
    logic        cfg_ok;
    logic [11:0] u_plus;
    logic [22:0] k1_w;

    assign u_plus = {1'b0, u_seg_reg} + 12'd1;
    assign cfg_ok = (u_seg_reg >= 11'd3) && ({2'b00, u_seg_reg} <= MAX_RES) &&
                    (v_ring_reg >= 11'd2) && ({2'b00, v_ring_reg} <= MAX_RES);
    assign k1_w   = 23'(req.ring) * 23'(u_plus) + 23'(req.segment);

    always_comb
    begin
        a_next.op      = req.op;
        a_next.ok      = cfg_ok && (req.op ?
                         (req.ring < v_ring_reg && req.segment < u_seg_reg) :
                         (req.ring <= v_ring_reg && req.segment <= u_seg_reg));
        a_next.tri_a   = req.ring != 11'd0;
        a_next.tri_b   = req.ring != 11'(v_ring_reg - 11'd1);
        a_next.k1      = k1_w[21:0];
        a_next.k2      = 22'(k1_w[21:0] + 22'(u_plus));
        a_next.ring    = req.ring;
        a_next.segment = req.segment;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NM; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
            for (int k = 1; k < NM; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= a_next;
            for (int k = 1; k < NM; k++)
                meta_reg[k] <= meta_reg[k-1];
        end
    end

    // dividers: phases and texels
    logic [DW-1:0] dvd_pu;
    logic [DW-1:0] dvd_pv;
    logic [DW-1:0] dvd_tu;
    logic [DW-1:0] dvd_tv;
    logic [QW-1:0] q_pu;
    logic [QW-1:0] q_pv;
    logic [QW-1:0] q_tu;
    logic [QW-1:0] q_tv;

    assign dvd_pu = (DW'(meta_reg[0].segment) << ANGLE_BITS) + DW'(u_seg_reg >> 1);
    assign dvd_pv = (DW'(meta_reg[0].ring) << (ANGLE_BITS - 1)) + DW'(v_ring_reg >> 1);
    assign dvd_tu = (DW'(11'(u_seg_reg - meta_reg[0].segment)) << 15) +
                    DW'(u_seg_reg >> 1);
    assign dvd_tv = (DW'(11'(v_ring_reg - meta_reg[0].ring)) << 15) +
                    DW'(v_ring_reg >> 1);

    uvsmg_div #(.QW(QW)) u_div_pu (.clk(clk), .en(adv), .dividend(dvd_pu),
                                   .divisor(u_seg_reg), .quotient(q_pu));
    uvsmg_div #(.QW(QW)) u_div_pv (.clk(clk), .en(adv), .dividend(dvd_pv),
                                   .divisor(v_ring_reg), .quotient(q_pv));
    uvsmg_div #(.QW(QW)) u_div_tu (.clk(clk), .en(adv), .dividend(dvd_tu),
                                   .divisor(u_seg_reg), .quotient(q_tu));
    uvsmg_div #(.QW(QW)) u_div_tv (.clk(clk), .en(adv), .dividend(dvd_tv),
                                   .divisor(v_ring_reg), .quotient(q_tv));

    tex_t tex_reg [NT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tex_reg[0] <= '{tu: q_tu[15:0], tv: q_tv[15:0]};
            for (int k = 1; k < NT; k++)
                tex_reg[k] <= tex_reg[k-1];
        end
    end

    // sine and cosine
    logic [ANGLE_BITS-1:0] ph_u;
    logic [ANGLE_BITS-1:0] ph_v;
    sc_t                   sc_u;
    sc_t                   sc_v;

    assign ph_u = q_pu[ANGLE_BITS-1:0];
    assign ph_v = QUARTER - q_pv[ANGLE_BITS-1:0];

    uvsmg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cor_u (.clk(clk), .en(adv), .phase(ph_u),
                                                     .sc(sc_u));
    uvsmg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cor_v (.clk(clk), .en(adv), .phase(ph_v),
                                                     .sc(sc_v));

    function automatic logic signed [16:0] mq14(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
        logic signed [33:0] p;
        p = (34'(a) * 34'(b) + 34'sd8192) >>> 14;
        return p[16:0];
    endfunction

    // stage M: unit vectors
    vtx_t m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg.x  <= mq14(17'(sc_v.c), 17'(sc_u.c));
            m_reg.z  <= mq14(17'(sc_v.c), 17'(sc_u.s));
            m_reg.y  <= 17'(sc_v.s);
            m_reg.cu <= sc_u.c;
            m_reg.su <= sc_u.s;
            m_reg.cv <= sc_v.c;
            m_reg.bx <= mq14(-17'(sc_v.s), 17'(sc_u.c));
            m_reg.bz <= mq14(-17'(sc_v.s), 17'(sc_u.s));
        end
    end

    // stage P1: radius partial products
    vtx_t               p1_reg;
    logic signed [33:0] lo_reg [3];
    logic signed [32:0] hi_reg [3];
    logic signed [16:0] axis   [3];

    assign axis[0] = m_reg.x;
    assign axis[1] = m_reg.y;
    assign axis[2] = m_reg.z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= m_reg;
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= signed'({1'b0, radius_reg[15:0]}) * 34'(axis[k]);
                hi_reg[k] <= signed'({1'b0, radius_reg[30:16]}) * 33'(axis[k]);
            end
        end
    end

    // stage P2: sum, round, offset and saturate
    vtx_t               p2_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] ctr     [3];

    assign ctr[0] = signed'(cx_reg);
    assign ctr[1] = signed'(cy_reg);
    assign ctr[2] = signed'(cz_reg);

    function automatic logic signed [31:0] place(input logic signed [32:0] hi,
                                                 input logic signed [33:0] lo,
                                                 input logic signed [31:0] c);
        logic signed [47:0] prod;
        logic signed [47:0] rnd;
        logic signed [34:0] sum;
        logic signed [31:0] r;
        prod = (48'(hi) <<< 16) + 48'(lo);
        rnd  = (prod + 48'sd8192) >>> 14;
        sum  = signed'(rnd[34:0]) + 35'(c);
        if (sum > 35'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (sum < -35'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = sum[31:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_reg <= p1_reg;
            for (int k = 0; k < 3; k++)
                pos_reg[k] <= place(hi_reg[k], lo_reg[k], ctr[k]);
        end
    end

    // beat sequencer
    meta_t              em_meta_reg;
    vtx_t               em_vtx_reg;
    tex_t               em_tex_reg;
    logic signed [31:0] em_pos_reg [3];
    logic [4:0]         pend_next;
    logic               tail_vld;
    meta_t              tail;

    assign tail_vld  = vld_reg[NM-1];
    assign tail      = meta_reg[NM-1];
    assign beat_last = (pend_reg & (pend_reg - 5'd1)) == 5'd0;
    assign emit_free = (pend_reg == 5'd0) || (rsp.ready && beat_last);
    assign adv       = emit_free || !tail_vld;

    always_comb
    begin
        if (!tail.ok)
            pend_next = 5'b00001;
        else if (tail.op)
            pend_next = {3'b000, tail.tri_b, tail.tri_a};
        else
            pend_next = {attr_reg[2], attr_reg[2], attr_reg[1], attr_reg[0], 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (emit_free)
            pend_reg <= tail_vld ? pend_next : 5'd0;
        else if (rsp.ready)
            pend_reg <= pend_reg & (pend_reg - 5'd1);
    end

    always_ff @(posedge clk)
    begin
        if (emit_free && tail_vld)
        begin
            em_meta_reg <= tail;
            em_vtx_reg  <= p2_reg;
            em_tex_reg  <= tex_reg[NT-1];
            for (int k = 0; k < 3; k++)
                em_pos_reg[k] <= pos_reg[k];
        end
    end

    logic [2:0]  sel;
    logic [2:0]  kind_c;
    logic [31:0] va_c;
    logic [31:0] vb_c;
    logic [31:0] vc_c;

    always_comb
    begin
        sel = 3'd4;
        for (int k = 3; k >= 0; k--)
            if (pend_reg[k])
                sel = 3'(k);
    end

    always_comb
    begin
        kind_c = KIND_ERR;
        va_c   = '0;
        vb_c   = '0;
        vc_c   = '0;
        if (!em_meta_reg.ok)
        begin
            kind_c = KIND_ERR;
        end
        else if (em_meta_reg.op)
        begin
            kind_c = KIND_TRI;
            if (sel == 3'd0)
            begin
                va_c = 32'(em_meta_reg.k1);
                vb_c = 32'(em_meta_reg.k2);
                vc_c = 32'(em_meta_reg.k1) + 32'd1;
            end
            else
            begin
                va_c = 32'(em_meta_reg.k1) + 32'd1;
                vb_c = 32'(em_meta_reg.k2);
                vc_c = 32'(em_meta_reg.k2) + 32'd1;
            end
        end
        else
        begin
            unique case (sel)
                3'd0:
                begin
                    kind_c = KIND_POS;
                    va_c   = em_pos_reg[0];
                    vb_c   = em_pos_reg[1];
                    vc_c   = em_pos_reg[2];
                end
                3'd1:
                begin
                    kind_c = KIND_TEX;
                    va_c   = 32'(em_tex_reg.tu);
                    vb_c   = 32'(em_tex_reg.tv);
                end
                3'd2:
                begin
                    kind_c = KIND_NRM;
                    va_c   = 32'(em_vtx_reg.x);
                    vb_c   = 32'(em_vtx_reg.y);
                    vc_c   = 32'(em_vtx_reg.z);
                end
                3'd3:
                begin
                    kind_c = KIND_TAN;
                    va_c   = 32'(em_vtx_reg.su);
                    vc_c   = 32'(em_vtx_reg.cu);
                end
                default:
                begin
                    kind_c = KIND_BIT;
                    va_c   = 32'(em_vtx_reg.bx);
                    vb_c   = 32'(em_vtx_reg.cv);
                    vc_c   = 32'(em_vtx_reg.bz);
                end
            endcase
        end
    end

    assign rsp.valid   = pend_reg != 5'd0;
    assign rsp.kind    = kind_c;
    assign rsp.value_a = va_c;
    assign rsp.value_b = vb_c;
    assign rsp.value_c = vc_c;
    assign rsp.last    = beat_last;
endmodule

// ===== rtl/uvsmg_chk.sv =====
// Port-level checker for the UV sphere mesh generator, bound to the top level.
module uvsmg_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_kind,
    input logic [31:0] rsp_value_a,
    input logic [31:0] rsp_value_b,
    input logic [31:0] rsp_value_c,
    input logic        rsp_last
);
    import uvsmg_pkg::*;

    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_ERR |->
        rsp_last && rsp_value_a == 32'd0 && rsp_value_b == 32'd0 && rsp_value_c == 32'd0)
        else $error("range error beat malformed");

    a_tex_c: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_TEX |-> rsp_value_c == 32'd0)
        else $error("texel beat with nonzero value_c");

    a_tan_b: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_TAN |-> rsp_value_b == 32'd0 && !rsp_last)
        else $error("tangent beat malformed");

    a_pos_next: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last && rsp_kind == KIND_POS |=>
        rsp_valid && (rsp_kind == KIND_TEX || rsp_kind == KIND_NRM || rsp_kind == KIND_TAN))
        else $error("vertex beats out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
        else $error("stalled beat changed");
endmodule

bind uv_sphere_mesh_generator_top uvsmg_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_kind    (rsp.kind),
    .rsp_value_a (rsp.value_a),
    .rsp_value_b (rsp.value_b),
    .rsp_value_c (rsp.value_c),
    .rsp_last    (rsp.last)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the UV sphere mesh generator top level.
`timescale 1ns / 1ps

module tb_top;
    import uvsmg_pkg::*;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_CELL   = 1'b1;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   DRAIN_CYCLES   = 60;

    typedef struct {
        logic        op;
        logic [10:0] ring;
        logic [10:0] segment;
    } mesh_req_t;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        last;
    } mesh_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    uvsmg_req_if req_ch();
    uvsmg_rsp_if rsp_ch();

    uv_sphere_mesh_generator_top DUT (
        .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the register file
    longint seg_cnt, ring_cnt, rad, ctr_x, ctr_y, ctr_z;
    logic [2:0] attr_en;

    mesh_req_t  pending_reqs[$];
    mesh_beat_t expected_beats[$];
    bit idle_on = 1'b1;
    int errors = 0;
    int reqs_sent = 0;
    int beats_seen = 0;
    int kind_seen[7];
    int quiet_cycles = 0;

    function automatic longint rnd_shift(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void sin_cos(input longint phase, output longint co, output longint si);
        logic [31:0] p;
        bit neg;
        longint x, y, z, dx, dy;
        p = {phase[15:0], 16'h0};
        neg = 1'b0;
        if (p + 32'h4000_0000 >= 32'h8000_0000)
        begin
            p = p - 32'h8000_0000;
            neg = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = longint'($signed(p));
        for (int k = 0; k < 16; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_q(k[3:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_q(k[3:0]));
            end
        end
        x = clip(rnd_shift(x, 16), -16384, 16384);
        y = clip(rnd_shift(y, 16), -16384, 16384);
        co = neg ? -x : x;
        si = neg ? -y : y;
    endfunction

    function automatic longint place(longint unit, longint ctr);
        return clip(rnd_shift(rad * unit, 14) + ctr, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic void add_beat(logic [2:0] kind, longint a, longint b, longint c);
        mesh_beat_t e;
        e.kind = kind; e.a = a[31:0]; e.b = b[31:0]; e.c = c[31:0]; e.last = 1'b0;
        expected_beats = {expected_beats, e};
    endfunction

    function automatic void predict_mesh(mesh_req_t r);
        longint i, j, pu, pv, cu, su, cv, sv, x, z, k1, k2;
        bit ok;
        i = r.ring;
        j = r.segment;
        ok = seg_cnt >= 3 && seg_cnt <= 1024 && ring_cnt >= 2 && ring_cnt <= 1024;
        if (ok)
            ok = (r.op == OP_CELL) ? (i < ring_cnt && j < seg_cnt)
                                   : (i <= ring_cnt && j <= seg_cnt);
        if (!ok)
            add_beat(KIND_ERR, 0, 0, 0);
        else if (r.op == OP_CELL)
        begin
            k1 = i * (seg_cnt + 1) + j;
            k2 = k1 + seg_cnt + 1;
            if (i != 0)
                add_beat(KIND_TRI, k1, k2, k1 + 1);
            if (i != ring_cnt - 1)
                add_beat(KIND_TRI, k1 + 1, k2, k2 + 1);
        end
        else
        begin
            pu = (j * 65536 + seg_cnt / 2) / seg_cnt;
            pv = 16384 - (i * 32768 + ring_cnt / 2) / ring_cnt;
            sin_cos(pu, cu, su);
            sin_cos(pv, cv, sv);
            x = rnd_shift(cv * cu, 14);
            z = rnd_shift(cv * su, 14);
            add_beat(KIND_POS, place(x, ctr_x), place(sv, ctr_y), place(z, ctr_z));
            if (attr_en[0])
                add_beat(KIND_TEX, ((seg_cnt - j) * 32768 + seg_cnt / 2) / seg_cnt,
                         ((ring_cnt - i) * 32768 + ring_cnt / 2) / ring_cnt, 0);
            if (attr_en[1])
                add_beat(KIND_NRM, x, sv, z);
            if (attr_en[2])
            begin
                add_beat(KIND_TAN, su, 0, cu);
                add_beat(KIND_BIT, rnd_shift(-sv * cu, 14), cv, rnd_shift(-sv * su, 14));
            end
        end
        expected_beats[expected_beats.size() - 1].last = 1'b1;
    endfunction

    // request driver
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.op <= 1'b0;
            req_ch.ring <= '0;
            req_ch.segment <= '0;
        end
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            automatic logic nv = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                predict_mesh(pending_reqs.pop_front());
                reqs_sent++;
            end
            if (send_gap > 0)
                send_gap--;
            else if (pending_reqs.size() > 0)
            begin
                if (idle_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(0, 10);
                else
                    nv = 1'b1;
            end
            req_ch.valid <= nv;
            if (nv)
            begin
                req_ch.op <= pending_reqs[0].op;
                req_ch.ring <= pending_reqs[0].ring;
                req_ch.segment <= pending_reqs[0].segment;
            end
        end
    end

    // result monitor and back-pressure
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                beats_seen++;
                if (rsp_ch.kind < 7)
                    kind_seen[rsp_ch.kind]++;
                if (expected_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat kind=%0d a=%h b=%h c=%h last=%b", $time,
                             rsp_ch.kind, rsp_ch.value_a, rsp_ch.value_b, rsp_ch.value_c,
                             rsp_ch.last);
                end
                else
                begin
                    automatic mesh_beat_t e = expected_beats.pop_front();
                    if (e.kind !== rsp_ch.kind || e.a !== rsp_ch.value_a ||
                        e.b !== rsp_ch.value_b || e.c !== rsp_ch.value_c ||
                        e.last !== rsp_ch.last)
                    begin
                        errors++;
                        $display("%0t: mismatch exp kind=%0d a=%h b=%h c=%h last=%b", $time,
                                 e.kind, e.a, e.b, e.c, e.last);
                        $display("%0t:          act kind=%0d a=%h b=%h c=%h last=%b", $time,
                                 rsp_ch.kind, rsp_ch.value_a, rsp_ch.value_b,
                                 rsp_ch.value_c, rsp_ch.last);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d beats outstanding", $time,
                     expected_beats.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ADDR_U_SEG:  seg_cnt = val[10:0];
            ADDR_V_RING: ring_cnt = val[10:0];
            ADDR_RADIUS: rad = val[30:0];
            ADDR_CX:     ctr_x = longint'($signed(val));
            ADDR_CY:     ctr_y = longint'($signed(val));
            ADDR_CZ:     ctr_z = longint'($signed(val));
            ADDR_ATTR:   attr_en = val[2:0];
            default: ;
        endcase
    endtask

    task automatic queue_req(logic op, int ring, int segment);
        mesh_req_t r;
        r.op = op; r.ring = 11'(ring); r.segment = 11'(segment);
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_beats.size() > 0 || req_ch.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_reqs(int n);
        int pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                          $urandom_range(0, 2047));
            else if (pick == 1)
                queue_req(1'($urandom_range(0, 1)), $urandom_range(0, ring_cnt + 1),
                          $urandom_range(0, seg_cnt + 1));
            else
                queue_req(1'($urandom_range(0, 1)), $urandom_range(0, ring_cnt),
                          $urandom_range(0, seg_cnt));
        end
    endtask

    initial
    begin
        seg_cnt = 32; ring_cnt = 16; rad = 65536;
        ctr_x = 0; ctr_y = 0; ctr_z = 0; attr_en = 3'd3;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: poles, seams, range edges, full-width fields
        reg_write(ADDR_ATTR, 32'd7);
        queue_req(OP_VERTEX, 0, 0);
        queue_req(OP_VERTEX, 16, 32);
        queue_req(OP_VERTEX, 8, 16);
        queue_req(OP_VERTEX, 17, 0);
        queue_req(OP_VERTEX, 0, 33);
        queue_req(OP_VERTEX, 11'h7FF, 11'h7FF);
        queue_req(OP_CELL, 0, 0);
        queue_req(OP_CELL, 15, 31);
        queue_req(OP_CELL, 7, 5);
        queue_req(OP_CELL, 16, 0);
        queue_req(OP_CELL, 0, 32);
        queue_req(OP_CELL, 11'h7FF, 11'h7FF);
        drain();

        // pause until idle mid-phase, then continue
        random_reqs(30);
        drain();
        random_reqs(30);
        drain();

        reg_write(ADDR_U_SEG, 32'd3);
        reg_write(ADDR_V_RING, 32'd2);
        reg_write(ADDR_RADIUS, 32'h7FFF_FFFF);
        reg_write(ADDR_CX, 32'h7FFF_FFFF);
        reg_write(ADDR_CY, 32'h8000_0000);
        reg_write(ADDR_CZ, 32'h0001_8000);
        queue_req(OP_VERTEX, 0, 0);
        queue_req(OP_VERTEX, 2, 3);
        queue_req(OP_CELL, 0, 2);
        queue_req(OP_CELL, 1, 0);
        random_reqs(50);
        drain();

        reg_write(ADDR_U_SEG, 32'd1024);
        reg_write(ADDR_V_RING, 32'd1024);
        reg_write(ADDR_RADIUS, 32'd0);
        reg_write(ADDR_CX, 32'h8000_0000);
        reg_write(ADDR_CY, 32'h7FFF_FFFF);
        reg_write(ADDR_CZ, 32'hFFFF_0000);
        reg_write(ADDR_ATTR, 32'd5);
        queue_req(OP_VERTEX, 1024, 1024);
        queue_req(OP_CELL, 1023, 1023);
        queue_req(OP_CELL, 1024, 1023);
        random_reqs(50);
        drain();

        // invalid geometry: everything errors
        reg_write(ADDR_U_SEG, 32'd2);
        random_reqs(12);
        drain();
        reg_write(ADDR_U_SEG, 32'd1025);
        reg_write(ADDR_V_RING, 32'd1);
        random_reqs(12);
        drain();
        reg_write(ADDR_V_RING, 32'd1025);
        reg_write(ADDR_U_SEG, 32'd40);
        random_reqs(12);
        drain();

        reg_write(ADDR_V_RING, 32'd37);
        reg_write(ADDR_U_SEG, 32'd97);
        reg_write(ADDR_RADIUS, 32'h0123_4567);
        reg_write(ADDR_CX, 32'hFFF8_0000);
        reg_write(ADDR_CY, 32'h0003_0000);
        reg_write(ADDR_CZ, 32'h0000_0001);
        reg_write(ADDR_ATTR, 32'd0);
        random_reqs(60);
        drain();

        reg_write(ADDR_ATTR, 32'd6);
        reg_write(ADDR_V_RING, 32'd5);
        reg_write(ADDR_U_SEG, 32'd7);
        random_reqs(60);
        drain();

        // final stretch at full rate
        idle_on = 1'b0;
        reg_write(ADDR_ATTR, 32'd7);
        reg_write(ADDR_RADIUS, 32'h0040_0000);
        random_reqs(60);
        drain();

        $display("Covered %0d requests, %0d beats across 9 register settings", reqs_sent,
                 beats_seen);
        $display("beats by kind: pos %0d tex %0d nrm %0d tan %0d bit %0d tri %0d err %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5], kind_seen[6]);
        if (errors == 0 && expected_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/uvsmg_pkg.sv
rtl/uvsmg_if.sv
rtl/uvsmg_div.sv
rtl/uvsmg_cordic.sv
rtl/uv_sphere_mesh_generator_top.sv
rtl/uvsmg_chk.sv
tb/sv/tb_top.sv
